// ===== rtl/tseu_pkg.sv =====
`timescale 1ns / 1ps
package tseu_pkg;

   localparam int MAX_POINTS      = 1024;
   localparam int MAX_DIMS        = 16;
   localparam int SIGMOID_ENTRIES = 256;

   localparam int POINT_W   = $clog2(MAX_POINTS);
   localparam int DIM_W     = $clog2(MAX_DIMS);
   localparam int ADDR_W    = POINT_W + DIM_W;
   localparam int DIMS_W    = 5;
   localparam int GIDX_W    = $clog2(SIGMOID_ENTRIES);
   localparam int GBUF_DEPTH = 3 * MAX_DIMS;
   localparam int GBUF_AW   = $clog2(GBUF_DEPTH);

   localparam longint GAIN_SPAN = 524288;
   localparam int GAIN_SHIFT = $clog2(2 * GAIN_SPAN / SIGMOID_ENTRIES);

   localparam logic [63:0] ONE_Q31 = 64'd2147483648;
   localparam logic [31:0] ONE_Q24 = 32'd16777216;

   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int SQ_W    = 49;
   localparam int ACC_W   = SQ_W + DIM_W;
   localparam int DIFF_W  = ACC_W + 1;
   localparam int WIDE_W  = 41;
   localparam int SCALE_W = 42;

   localparam int DIV_NUM_W = 56;
   localparam int DIV_DEN_W = 48;
   localparam int DIV_Q_W   = 32;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_TRAIN = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_DIMS       = 2'd0,
      CSR_STEP_INIT  = 2'd1,
      CSR_STEP_PARAM = 2'd2,
      CSR_MODE       = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      TAG_NONE, TAG_DAB, TAG_DAC, TAG_GRAD, TAG_DEN, TAG_R, TAG_ETA, TAG_UPD
   } tag_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_READ_WAIT,
      ST_RA, ST_RB, ST_RC, ST_SQB, ST_SQC, ST_GAIN_WAIT, ST_GAIN,
      ST_G1, ST_G2, ST_G0,
      ST_ETA, ST_DEN_WAIT, ST_DIV_GO, ST_DIV_WAIT,
      ST_GEO_SQ, ST_GEO_SQW, ST_GEO_MP, ST_GEO_MPW, ST_GEO_FIN, ST_ETA_WAIT,
      ST_U_RD, ST_U_MUL, ST_U_WR, ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [9:0]         point_a;
      logic [9:0]         point_b;
      logic [9:0]         point_c;
      logic [3:0]         coord_index;
      logic signed [31:0] coord_value;
      logic [15:0]        epoch;
   } request_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic               saturated;
   } response_type;

   // exp(-t) in Q1.31, t in Q16.16
   function automatic logic [63:0] exp_neg_q31(input logic [63:0] t);
      logic [63:0] y, y2, y3, y4, e;
      y  = t << 7;
      y2 = (y * y) >> 31;
      y3 = (y2 * y) >> 31;
      y4 = (y3 * y) >> 31;
      e  = ONE_Q31 - y + (y2 >> 1) - y3 / 64'd6 + y4 / 64'd24;
      for (int i = 0; i < 8; i++) begin
         e = (e * e) >> 31;
      end
      return e;
   endfunction

   function automatic logic [MUL_W-1:0] mag_diff(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [MUL_W-1:0] dd;
      dd = MUL_W'(a) - MUL_W'(b);
      return dd[MUL_W-1] ? MUL_W'(-dd) : MUL_W'(dd);
   endfunction

   // {clipped, value}
   function automatic logic [32:0] clip_int32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi, lo;
      hi = WIDE_W'(32'sh7FFF_FFFF);
      lo = -WIDE_W'(64'sh8000_0000);
      if (v > hi)      return {1'b1, 32'h7FFF_FFFF};
      else if (v < lo) return {1'b1, 32'h8000_0000};
      else             return {1'b0, v[31:0]};
   endfunction

   function automatic logic [31:0] sat_u32(input logic [SCALE_W-1:0] v);
      return (|v[SCALE_W-1:32]) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

endpackage

// ===== rtl/triplet_embedding_sgd_update_unit.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// request   start / busy              req_data  (tseu_pkg::request_type)
// response  rsp_valid (strobe)        rsp_data  (tseu_pkg::response_type)
// csr       csr_valid / csr_ready     csr_index, csr_data
//
// One request at a time; busy stays high until its single response strobe.
// Train derives the step size from the bit-serial divider in inverse mode
// or from one shared 33x33 multiplier in geometric mode.
// Synchronous reset clears control and configuration registers only; the store needs no clear.
// The receiver cannot stall: each response is taken in its strobe cycle.
module triplet_embedding_sgd_update_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tseu_pkg::request_type  req_data,
   output logic                   rsp_valid,
   output tseu_pkg::response_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data
);

   tseu_pkg::state_type state_ff, state_in;
   tseu_pkg::tag_type   tag_ff, tag_in;
   tseu_pkg::request_type req_ff;

   logic [tseu_pkg::DIMS_W-1:0] dims_ff, dims_eff;
   logic [31:0] step_init_ff, step_param_ff;
   logic        mode_ff;

   logic [tseu_pkg::DIM_W-1:0] d_ff;
   logic [1:0]                 rr_ff;
   logic [3:0]                 bit_ff;
   logic                       pass_ff;
   logic                       sat_ff;
   logic signed [31:0]         rsp_value_ff;

   logic signed [31:0] store [1 << tseu_pkg::ADDR_W];
   logic signed [31:0] gbuf  [tseu_pkg::GBUF_DEPTH];
   logic signed [31:0] rdata_ff, gbuf_rdata_ff;
   logic [tseu_pkg::ADDR_W-1:0]  raddr, store_waddr;
   logic signed [31:0]           store_wdata;
   logic                         store_we;
   logic [tseu_pkg::GBUF_AW-1:0] gaddr;
   logic [1:0]                   sub_idx;
   logic [tseu_pkg::POINT_W-1:0] pt_sel;

   logic signed [31:0] xa_ff, xb_ff, xc_ff, x_old_ff;
   logic [tseu_pkg::ACC_W-1:0] dab_ff, dac_ff;
   logic [31:0] gain_ff, r_ff, eta_ff;
   logic [tseu_pkg::DIV_DEN_W-1:0] den_ff;

   logic [tseu_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic [tseu_pkg::PROD_W-1:0] prod_ff;
   logic                        neg_in, wb_neg_ff;
   logic [tseu_pkg::GBUF_AW-1:0] wb_gaddr_ff;
   logic [tseu_pkg::ADDR_W-1:0]  wb_saddr_ff;

   logic signed [tseu_pkg::DIFF_W-1:0] gdiff, gsum;
   logic [tseu_pkg::GIDX_W-1:0]        gidx;
   logic [31:0]                        rom_gain;

   logic [tseu_pkg::WIDE_W-1:0]        grad_mag, upd_mag;
   logic signed [tseu_pkg::WIDE_W-1:0] grad_val, upd_val;
   logic [32:0]                        grad_clip, upd_clip;
   logic [31:0]                        scaled_sat;

   logic div_start, div_done;
   logic [tseu_pkg::DIV_Q_W-1:0] div_quot;
   logic accept, d_last;

   assign accept    = start && !busy;
   assign busy      = state_ff != tseu_pkg::ST_IDLE;
   assign csr_ready = !busy;
   assign rsp_valid = state_ff == tseu_pkg::ST_DONE;
   assign rsp_data  = '{read_value: rsp_value_ff, saturated: sat_ff};

   assign dims_eff = (dims_ff > tseu_pkg::DIMS_W'(tseu_pkg::MAX_DIMS))
                   ? tseu_pkg::DIMS_W'(tseu_pkg::MAX_DIMS) : dims_ff;
   assign d_last   = {1'b0, d_ff} == dims_eff - 1'b1;

   // gain table index with saturation outside the span
   assign gdiff = $signed({1'b0, dab_ff}) - $signed({1'b0, dac_ff});
   assign gsum  = gdiff + tseu_pkg::DIFF_W'(tseu_pkg::GAIN_SPAN);
   always_comb begin
      if (gdiff < -tseu_pkg::DIFF_W'(tseu_pkg::GAIN_SPAN))
         gidx = '0;
      else if (gdiff >= tseu_pkg::DIFF_W'(tseu_pkg::GAIN_SPAN))
         gidx = '1;
      else
         gidx = gsum[tseu_pkg::GAIN_SHIFT +: tseu_pkg::GIDX_W];
   end

   tseu_gain_rom u_gain_rom (
      .index (gidx),
      .gain  (rom_gain)
   );

   tseu_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer ({step_init_ff, 24'd0}),
      .denom (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tseu_pkg::ST_IDLE:      if (start) state_in = tseu_pkg::ST_DECODE;
         tseu_pkg::ST_DECODE: begin
            unique case (req_ff.cmd)
               tseu_pkg::CMD_READ:  state_in = tseu_pkg::ST_READ_WAIT;
               tseu_pkg::CMD_TRAIN: state_in = (dims_eff == '0) ? tseu_pkg::ST_DONE
                                                                : tseu_pkg::ST_RA;
               default:             state_in = tseu_pkg::ST_DONE;
            endcase
         end
         tseu_pkg::ST_READ_WAIT: state_in = tseu_pkg::ST_DONE;
         tseu_pkg::ST_RA:        state_in = tseu_pkg::ST_RB;
         tseu_pkg::ST_RB:        state_in = tseu_pkg::ST_RC;
         tseu_pkg::ST_RC:        state_in = pass_ff ? tseu_pkg::ST_G1 : tseu_pkg::ST_SQB;
         tseu_pkg::ST_SQB:       state_in = tseu_pkg::ST_SQC;
         tseu_pkg::ST_SQC:       state_in = d_last ? tseu_pkg::ST_GAIN_WAIT : tseu_pkg::ST_RA;
         tseu_pkg::ST_GAIN_WAIT: state_in = tseu_pkg::ST_GAIN;
         tseu_pkg::ST_GAIN:      state_in = tseu_pkg::ST_RA;
         tseu_pkg::ST_G1:        state_in = tseu_pkg::ST_G2;
         tseu_pkg::ST_G2:        state_in = tseu_pkg::ST_G0;
         tseu_pkg::ST_G0:        state_in = d_last ? tseu_pkg::ST_ETA : tseu_pkg::ST_RA;
         tseu_pkg::ST_ETA:       state_in = mode_ff ? tseu_pkg::ST_GEO_SQ
                                                    : tseu_pkg::ST_DEN_WAIT;
         tseu_pkg::ST_DEN_WAIT:  state_in = tseu_pkg::ST_DIV_GO;
         tseu_pkg::ST_DIV_GO:    state_in = tseu_pkg::ST_DIV_WAIT;
         tseu_pkg::ST_DIV_WAIT:  if (div_done) state_in = tseu_pkg::ST_U_RD;
         tseu_pkg::ST_GEO_SQ:    state_in = tseu_pkg::ST_GEO_SQW;
         tseu_pkg::ST_GEO_SQW: begin
            if (req_ff.epoch[bit_ff])  state_in = tseu_pkg::ST_GEO_MP;
            else if (bit_ff == '0)     state_in = tseu_pkg::ST_GEO_FIN;
            else                       state_in = tseu_pkg::ST_GEO_SQ;
         end
         tseu_pkg::ST_GEO_MP:    state_in = tseu_pkg::ST_GEO_MPW;
         tseu_pkg::ST_GEO_MPW:   state_in = (bit_ff == '0) ? tseu_pkg::ST_GEO_FIN
                                                           : tseu_pkg::ST_GEO_SQ;
         tseu_pkg::ST_GEO_FIN:   state_in = tseu_pkg::ST_ETA_WAIT;
         tseu_pkg::ST_ETA_WAIT:  state_in = tseu_pkg::ST_U_RD;
         tseu_pkg::ST_U_RD:      state_in = tseu_pkg::ST_U_MUL;
         tseu_pkg::ST_U_MUL:     state_in = tseu_pkg::ST_U_WR;
         tseu_pkg::ST_U_WR:      state_in = (d_last && rr_ff == 2'd2) ? tseu_pkg::ST_DONE
                                                                      : tseu_pkg::ST_U_RD;
         tseu_pkg::ST_DONE:      state_in = tseu_pkg::ST_IDLE;
         default:                state_in = tseu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      case (rr_ff)
         2'd1:    pt_sel = req_ff.point_b;
         2'd2:    pt_sel = req_ff.point_c;
         default: pt_sel = req_ff.point_a;
      endcase
   end

   // datapath controls
   always_comb begin
      raddr     = {req_ff.point_a, d_ff};
      sub_idx   = rr_ff;
      mul_a     = '0;
      mul_b     = '0;
      neg_in    = 1'b0;
      tag_in    = tseu_pkg::TAG_NONE;
      div_start = 1'b0;
      unique case (state_ff)
         tseu_pkg::ST_DECODE: raddr = {req_ff.point_a, req_ff.coord_index};
         tseu_pkg::ST_RB:     raddr = {req_ff.point_b, d_ff};
         tseu_pkg::ST_RC:     raddr = {req_ff.point_c, d_ff};
         tseu_pkg::ST_U_RD:   raddr = {pt_sel, d_ff};
         tseu_pkg::ST_SQB: begin
            mul_a  = tseu_pkg::mag_diff(xa_ff, xb_ff);
            mul_b  = mul_a;
            tag_in = tseu_pkg::TAG_DAB;
         end
         tseu_pkg::ST_SQC: begin
            mul_a  = tseu_pkg::mag_diff(xa_ff, xc_ff);
            mul_b  = mul_a;
            tag_in = tseu_pkg::TAG_DAC;
         end
         tseu_pkg::ST_G1: begin
            mul_a   = tseu_pkg::MUL_W'(gain_ff);
            mul_b   = tseu_pkg::mag_diff(xb_ff, xa_ff);
            neg_in  = xb_ff < xa_ff;
            sub_idx = 2'd1;
            tag_in  = tseu_pkg::TAG_GRAD;
         end
         tseu_pkg::ST_G2: begin
            mul_a   = tseu_pkg::MUL_W'(gain_ff);
            mul_b   = tseu_pkg::mag_diff(xa_ff, xc_ff);
            neg_in  = xa_ff < xc_ff;
            sub_idx = 2'd2;
            tag_in  = tseu_pkg::TAG_GRAD;
         end
         tseu_pkg::ST_G0: begin
            mul_a   = tseu_pkg::MUL_W'(gain_ff);
            mul_b   = tseu_pkg::mag_diff(xc_ff, xb_ff);
            neg_in  = xc_ff < xb_ff;
            sub_idx = 2'd0;
            tag_in  = tseu_pkg::TAG_GRAD;
         end
         tseu_pkg::ST_ETA: begin
            mul_a  = tseu_pkg::MUL_W'(step_param_ff);
            mul_b  = tseu_pkg::MUL_W'(req_ff.epoch);
            tag_in = mode_ff ? tseu_pkg::TAG_NONE : tseu_pkg::TAG_DEN;
         end
         tseu_pkg::ST_DIV_GO: div_start = 1'b1;
         tseu_pkg::ST_GEO_SQ: begin
            mul_a  = tseu_pkg::MUL_W'(r_ff);
            mul_b  = tseu_pkg::MUL_W'(r_ff);
            tag_in = tseu_pkg::TAG_R;
         end
         tseu_pkg::ST_GEO_MP: begin
            mul_a  = tseu_pkg::MUL_W'(r_ff);
            mul_b  = tseu_pkg::MUL_W'(step_param_ff);
            tag_in = tseu_pkg::TAG_R;
         end
         tseu_pkg::ST_GEO_FIN: begin
            mul_a  = tseu_pkg::MUL_W'(step_init_ff);
            mul_b  = tseu_pkg::MUL_W'(r_ff);
            tag_in = tseu_pkg::TAG_ETA;
         end
         tseu_pkg::ST_U_MUL: begin
            mul_a  = tseu_pkg::MUL_W'(eta_ff);
            mul_b  = tseu_pkg::mag_diff(gbuf_rdata_ff, 32'sd0);
            neg_in = gbuf_rdata_ff[31];
            raddr  = {pt_sel, d_ff};
            tag_in = tseu_pkg::TAG_UPD;
         end
         default: ;
      endcase
   end

   assign gaddr = tseu_pkg::GBUF_AW'({d_ff, 1'b0}) + tseu_pkg::GBUF_AW'(d_ff)
                + tseu_pkg::GBUF_AW'(sub_idx);

   // product writeback
   assign grad_mag   = prod_ff[16 +: tseu_pkg::WIDE_W];
   assign grad_val   = wb_neg_ff ? -$signed(grad_mag) : $signed(grad_mag);
   assign grad_clip  = tseu_pkg::clip_int32(grad_val);
   assign upd_mag    = prod_ff[24 +: tseu_pkg::WIDE_W];
   assign upd_val    = wb_neg_ff ? tseu_pkg::WIDE_W'(x_old_ff) + $signed(upd_mag)
                                 : tseu_pkg::WIDE_W'(x_old_ff) - $signed(upd_mag);
   assign upd_clip   = tseu_pkg::clip_int32(upd_val);
   assign scaled_sat = tseu_pkg::sat_u32(prod_ff[24 +: tseu_pkg::SCALE_W]);

   always_comb begin
      store_we    = 1'b0;
      store_waddr = {req_ff.point_a, req_ff.coord_index};
      store_wdata = req_ff.coord_value;
      if (tag_ff == tseu_pkg::TAG_UPD) begin
         store_we    = 1'b1;
         store_waddr = wb_saddr_ff;
         store_wdata = upd_clip[31:0];
      end else if (state_ff == tseu_pkg::ST_DECODE
                   && req_ff.cmd == tseu_pkg::CMD_WRITE) begin
         store_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) store[store_waddr] <= store_wdata;
      rdata_ff <= store[raddr];
      if (tag_ff == tseu_pkg::TAG_GRAD) gbuf[wb_gaddr_ff] <= grad_clip[31:0];
      gbuf_rdata_ff <= gbuf[gaddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tseu_pkg::ST_IDLE;
         tag_ff        <= tseu_pkg::TAG_NONE;
         dims_ff       <= tseu_pkg::DIMS_W'(2);
         step_init_ff  <= tseu_pkg::ONE_Q24;
         step_param_ff <= tseu_pkg::ONE_Q24;
         mode_ff       <= 1'b0;
         d_ff          <= '0;
         rr_ff         <= '0;
         bit_ff        <= '0;
         pass_ff       <= 1'b0;
         sat_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         tag_ff   <= tag_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               tseu_pkg::CSR_DIMS:       dims_ff       <= csr_data[tseu_pkg::DIMS_W-1:0];
               tseu_pkg::CSR_STEP_INIT:  step_init_ff  <= csr_data;
               tseu_pkg::CSR_STEP_PARAM: step_param_ff <= csr_data;
               tseu_pkg::CSR_MODE:       mode_ff       <= csr_data[0];
               default: ;
            endcase
         end
         if (accept) begin
            sat_ff  <= 1'b0;
            d_ff    <= '0;
            pass_ff <= 1'b0;
         end
         if ((tag_ff == tseu_pkg::TAG_GRAD && grad_clip[32])
             || (tag_ff == tseu_pkg::TAG_UPD && upd_clip[32]))
            sat_ff <= 1'b1;
         case (state_ff) inside
            tseu_pkg::ST_SQC, tseu_pkg::ST_G0: if (!d_last) d_ff <= d_ff + 1'b1;
            tseu_pkg::ST_GAIN: begin
               d_ff    <= '0;
               pass_ff <= 1'b1;
            end
            tseu_pkg::ST_ETA: begin
               d_ff   <= '0;
               rr_ff  <= '0;
               bit_ff <= 4'd15;
            end
            tseu_pkg::ST_GEO_SQW:
               if (!req_ff.epoch[bit_ff] && bit_ff != '0) bit_ff <= bit_ff - 1'b1;
            tseu_pkg::ST_GEO_MPW: if (bit_ff != '0) bit_ff <= bit_ff - 1'b1;
            tseu_pkg::ST_U_WR: begin
               if (rr_ff == 2'd2) begin
                  rr_ff <= '0;
                  d_ff  <= d_ff + 1'b1;
               end else begin
                  rr_ff <= rr_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= mul_a * mul_b;
      wb_neg_ff   <= neg_in;
      wb_gaddr_ff <= gaddr;
      wb_saddr_ff <= raddr;
      if (accept) begin
         req_ff       <= req_data;
         rsp_value_ff <= '0;
         dab_ff       <= '0;
         dac_ff       <= '0;
      end
      case (state_ff) inside
         tseu_pkg::ST_READ_WAIT: rsp_value_ff <= rdata_ff;
         tseu_pkg::ST_RB:        xa_ff <= rdata_ff;
         tseu_pkg::ST_RC:        xb_ff <= rdata_ff;
         tseu_pkg::ST_SQB, tseu_pkg::ST_G1: xc_ff <= rdata_ff;
         tseu_pkg::ST_GAIN:      gain_ff <= rom_gain;
         tseu_pkg::ST_ETA:       r_ff <= tseu_pkg::ONE_Q24;
         tseu_pkg::ST_DIV_WAIT:  if (div_done) eta_ff <= div_quot;
         tseu_pkg::ST_U_MUL:     x_old_ff <= rdata_ff;
         default: ;
      endcase
      case (tag_ff)
         tseu_pkg::TAG_DAB: dab_ff <= dab_ff + tseu_pkg::ACC_W'(prod_ff[16 +: tseu_pkg::SQ_W]);
         tseu_pkg::TAG_DAC: dac_ff <= dac_ff + tseu_pkg::ACC_W'(prod_ff[16 +: tseu_pkg::SQ_W]);
         tseu_pkg::TAG_DEN: den_ff <= tseu_pkg::DIV_DEN_W'(tseu_pkg::ONE_Q24)
                                    + prod_ff[tseu_pkg::DIV_DEN_W-1:0];
         tseu_pkg::TAG_R:   r_ff   <= scaled_sat;
         tseu_pkg::TAG_ETA: eta_ff <= scaled_sat;
         default: ;
      endcase
   end

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response outside a busy request");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("accepted request did not raise busy");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe longer than one cycle");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == tseu_pkg::ST_DIV_WAIT) else $error("divider result unused");
   a_upd_wb: assert property (@(posedge clock) disable iff (reset)
      tag_ff == tseu_pkg::TAG_UPD |-> state_ff == tseu_pkg::ST_U_WR)
      else $error("update writeback out of sequence");

endmodule

// ===== rtl/tseu_gain_rom.sv =====
`timescale 1ns / 1ps
module tseu_gain_rom (
   input  logic [tseu_pkg::GIDX_W-1:0] index,
   output logic [31:0]                 gain
);

   logic [31:0] rom [tseu_pkg::SIGMOID_ENTRIES];

   // 2*sigmoid at the midpoint of each bin, unsigned Q16.16
   for (genvar k = 0; k < tseu_pkg::SIGMOID_ENTRIES; k++) begin : g_entry
      localparam longint XS = -tseu_pkg::GAIN_SPAN
         + ((2 * k + 1) * tseu_pkg::GAIN_SPAN) / tseu_pkg::SIGMOID_ENTRIES;
      localparam logic [63:0] TV = 64'((XS < 0) ? -XS : XS);
      localparam logic [63:0] EV = tseu_pkg::exp_neg_q31(TV);
      localparam logic [63:0] GV = (XS >= 0)
         ? ((64'd1 << 48) / (tseu_pkg::ONE_Q31 + EV))
         : ((EV << 17) / (tseu_pkg::ONE_Q31 + EV));
      assign rom[k] = GV[31:0];
   end

   assign gain = rom[index];

endmodule

// ===== rtl/tseu_divider.sv =====
`timescale 1ns / 1ps
module tseu_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tseu_pkg::DIV_NUM_W-1:0]  numer,
   input  logic [tseu_pkg::DIV_DEN_W-1:0]  denom,
   output logic                            done,
   output logic [tseu_pkg::DIV_Q_W-1:0]    quot
);

   logic [tseu_pkg::DIV_NUM_W-1:0] num_ff;
   logic [tseu_pkg::DIV_DEN_W-1:0] den_ff, rem_ff, rem_in;
   logic [tseu_pkg::DIV_Q_W-1:0]   quot_ff;
   logic [tseu_pkg::DIV_CNT_W-1:0] count_ff;
   logic                           run_ff, done_ff;
   logic [tseu_pkg::DIV_DEN_W:0]   shifted;
   logic                           fits;
   logic                           last;

   // restoring division, one quotient bit per cycle
   assign shifted = {rem_ff, num_ff[tseu_pkg::DIV_NUM_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign rem_in  = fits ? tseu_pkg::DIV_DEN_W'(shifted - {1'b0, den_ff})
                         : shifted[tseu_pkg::DIV_DEN_W-1:0];
   assign last    = count_ff == tseu_pkg::DIV_CNT_W'(tseu_pkg::DIV_NUM_W - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= run_ff && last;
         if (start) begin
            run_ff   <= 1'b1;
            count_ff <= '0;
         end else if (run_ff) begin
            if (last) run_ff <= 1'b0;
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numer;
         den_ff <= denom;
         rem_ff <= '0;
      end else if (run_ff) begin
         num_ff  <= {num_ff[tseu_pkg::DIV_NUM_W-2:0], 1'b0};
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[tseu_pkg::DIV_Q_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== dv/tb_triplet_embedding_sgd_update_unit.sv =====
`timescale 1ns / 1ps
module tb_triplet_embedding_sgd_update_unit;

   localparam longint SPAN_Q16 = 524288;
   localparam int     N_PHASES = 10;
   localparam int     PHASE_ITEMS = 100;
   localparam int     N_COORDS = tseu_pkg::MAX_POINTS * tseu_pkg::MAX_DIMS;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   tseu_pkg::request_type  req_data;
   logic                   rsp_valid;
   tseu_pkg::response_type rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [1:0]             csr_index;
   logic [31:0]            csr_data;

   triplet_embedding_sgd_update_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   typedef struct packed {
      tseu_pkg::request_type  req;
      logic                   fixed;
      tseu_pkg::response_type rsp;
   } vector_type;

   typedef struct packed {
      logic [31:0] dims;
      logic [31:0] eta0;
      logic [31:0] param;
      logic [31:0] mode;
   } setting_type;

   // shadow copy of the block's state
   logic signed [31:0] coord_mem [N_COORDS];
   bit                 coord_known [N_COORDS];
   int                 known_addrs [$];
   logic [31:0]        gain_lut [tseu_pkg::SIGMOID_ENTRIES];
   logic [4:0]         cfg_dims;
   logic [31:0]        cfg_eta0;
   logic [31:0]        cfg_param;
   logic               cfg_mode;

   tseu_pkg::response_type expected_rsp [$];
   int                     errors;
   bit                     no_idle;
   int                     pool [8] = '{0, 1, 2, 3, 5, 341, 682, 1023};
   vector_type             vectors [$];
   setting_type            settings [N_PHASES];

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #100_000_000;
      $display("status: fail");
      $finish;
   end

   task automatic flag_error(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic logic [63:0] exp_neg(input logic [63:0] t);
      logic [63:0] y, y2, y3, y4, e;
      y  = t << 7;
      y2 = (y * y) >> 31;
      y3 = (y2 * y) >> 31;
      y4 = (y3 * y) >> 31;
      e  = 64'd2147483648 - y + (y2 >> 1) - y3 / 64'd6 + y4 / 64'd24;
      repeat (8) e = (e * e) >> 31;
      return e;
   endfunction

   function automatic logic [63:0] mul_q24(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = (a * b) >> 24;
      return (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
   endfunction

   function automatic logic [63:0] step_size(input logic [15:0] ep);
      logic [63:0] r;
      if (!cfg_mode)
         return ({32'd0, cfg_eta0} << 24)
                / (64'd16777216 + {32'd0, cfg_param} * {48'd0, ep});
      r = 64'd16777216;
      for (int b = 15; b >= 0; b--) begin
         r = mul_q24(r, r);
         if (ep[b]) r = mul_q24(r, {32'd0, cfg_param});
      end
      return mul_q24({32'd0, cfg_eta0}, r);
   endfunction

   function automatic longint scale_mag(input logic [63:0] m, input longint v, input int sh);
      logic [63:0] mag, p;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      p   = (m * mag) >> sh;
      return (v < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic logic signed [31:0] clip(input longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic [63:0] sq_q16(input longint dv);
      logic [63:0] m;
      m = (dv < 0) ? 64'(-dv) : 64'(dv);
      return (m * m) >> 16;
   endfunction

   // applies one request to the shadow state and returns its response
   function automatic tseu_pkg::response_type apply_request(input tseu_pkg::request_type r);
      tseu_pkg::response_type o;
      int                     pt [3];
      int                     nd, k;
      logic [63:0]            dab, dac, eta, g;
      longint                 x, xa, xb, xc;
      logic signed [31:0]     grad [tseu_pkg::MAX_DIMS][3];
      bit                     sat;
      o   = '0;
      sat = 1'b0;
      pt  = '{int'(r.point_a), int'(r.point_b), int'(r.point_c)};
      case (tseu_pkg::cmd_type'(r.cmd))
         tseu_pkg::CMD_WRITE: begin
            k = pt[0] * tseu_pkg::MAX_DIMS + int'(r.coord_index);
            coord_mem[k] = r.coord_value;
            if (!coord_known[k]) begin
               coord_known[k] = 1'b1;
               known_addrs.push_back(k);
            end
         end
         tseu_pkg::CMD_READ:
            o.read_value = coord_mem[pt[0] * tseu_pkg::MAX_DIMS + int'(r.coord_index)];
         tseu_pkg::CMD_TRAIN: begin
            nd  = (cfg_dims > tseu_pkg::MAX_DIMS) ? tseu_pkg::MAX_DIMS : int'(cfg_dims);
            dab = 0;
            dac = 0;
            for (int d = 0; d < nd; d++) begin
               xa = coord_mem[pt[0] * tseu_pkg::MAX_DIMS + d];
               xb = coord_mem[pt[1] * tseu_pkg::MAX_DIMS + d];
               xc = coord_mem[pt[2] * tseu_pkg::MAX_DIMS + d];
               dab += sq_q16(xa - xb);
               dac += sq_q16(xa - xc);
            end
            x = longint'(dab) - longint'(dac);
            if (x < -SPAN_Q16) k = 0;
            else if (x >= SPAN_Q16) k = tseu_pkg::SIGMOID_ENTRIES - 1;
            else k = int'(((x + SPAN_Q16) * tseu_pkg::SIGMOID_ENTRIES) / (2 * SPAN_Q16));
            g = {32'd0, gain_lut[k]};
            for (int d = 0; d < nd; d++) begin
               xa = coord_mem[pt[0] * tseu_pkg::MAX_DIMS + d];
               xb = coord_mem[pt[1] * tseu_pkg::MAX_DIMS + d];
               xc = coord_mem[pt[2] * tseu_pkg::MAX_DIMS + d];
               grad[d][0] = clip(scale_mag(g, xc - xb, 16), sat);
               grad[d][1] = clip(scale_mag(g, xb - xa, 16), sat);
               grad[d][2] = clip(scale_mag(g, xa - xc, 16), sat);
            end
            eta = step_size(r.epoch);
            for (int d = 0; d < nd; d++)
               for (int j = 0; j < 3; j++) begin
                  k = pt[j] * tseu_pkg::MAX_DIMS + d;
                  coord_mem[k] = clip(longint'(coord_mem[k])
                                      - scale_mag(eta, longint'(grad[d][j]), 24), sat);
               end
            o.saturated = sat;
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            flag_error("response with no request outstanding");
         end else begin
            if (rsp_data.read_value !== expected_rsp[0].read_value)
               flag_error($sformatf("read_value %h, expected %h", rsp_data.read_value,
                                    expected_rsp[0].read_value));
            if (rsp_data.saturated !== expected_rsp[0].saturated)
               flag_error($sformatf("saturated %b, expected %b", rsp_data.saturated,
                                    expected_rsp[0].saturated));
            void'(expected_rsp.pop_front());
         end
      end
   end

   task automatic wait_drained();
      while (expected_rsp.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic send_request(input tseu_pkg::request_type r, input bit fixed,
                               input tseu_pkg::response_type fr);
      tseu_pkg::response_type o;
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      start    = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
      o = apply_request(r);
      expected_rsp.push_back(fixed ? fr : o);
   endtask

   task automatic write_csr(input tseu_pkg::csr_type idx, input logic [31:0] v);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         tseu_pkg::CSR_DIMS:       cfg_dims  = v[4:0];
         tseu_pkg::CSR_STEP_INIT:  cfg_eta0  = v;
         tseu_pkg::CSR_STEP_PARAM: cfg_param = v;
         default:                  cfg_mode  = v[0];
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [31:0] coord_rand();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($urandom_range(0, 524288)) - 32'd262144;
      endcase
   endfunction

   function automatic tseu_pkg::request_type random_request();
      tseu_pkg::request_type r;
      int                    sel, k;
      r = '{cmd: tseu_pkg::CMD_NONE, point_a: 10'($urandom), point_b: 10'($urandom),
            point_c: 10'($urandom), coord_index: 4'($urandom), coord_value: coord_rand(),
            epoch: ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24))};
      sel = $urandom_range(0, 19);
      if (sel < 10) begin
         r.cmd     = tseu_pkg::CMD_TRAIN;
         r.point_a = 10'(pool[$urandom_range(0, 7)]);
         r.point_b = 10'(pool[$urandom_range(0, 7)]);
         r.point_c = 10'(pool[$urandom_range(0, 7)]);
      end else if (sel < 15) begin
         r.cmd = tseu_pkg::CMD_WRITE;
         if ($urandom_range(0, 2) != 0) r.point_a = 10'(pool[$urandom_range(0, 7)]);
      end else if (sel < 19) begin
         r.cmd         = tseu_pkg::CMD_READ;
         k             = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
         r.point_a     = 10'(k / tseu_pkg::MAX_DIMS);
         r.coord_index = 4'(k % tseu_pkg::MAX_DIMS);
      end
      return r;
   endfunction

   function automatic vector_type vec(input tseu_pkg::cmd_type c, input int a, input int b,
                                      input int cc, input int ci, input logic [31:0] v,
                                      input int ep, input bit fixed, input logic [31:0] rv);
      vector_type t;
      t.req   = '{cmd: c, point_a: 10'(a), point_b: 10'(b), point_c: 10'(cc),
                  coord_index: 4'(ci), coord_value: v, epoch: 16'(ep)};
      t.fixed = fixed;
      t.rsp   = '{read_value: rv, saturated: 1'b0};
      return t;
   endfunction

   initial begin
      logic [63:0]           e;
      longint                x;
      tseu_pkg::request_type r;
      errors    = 0;
      no_idle   = 1'b0;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      cfg_dims  = 5'd2;
      cfg_eta0  = 32'd16777216;
      cfg_param = 32'd16777216;
      cfg_mode  = 1'b0;
      for (int k = 0; k < tseu_pkg::SIGMOID_ENTRIES; k++) begin
         x = -SPAN_Q16 + ((2 * k + 1) * SPAN_Q16) / tseu_pkg::SIGMOID_ENTRIES;
         e = exp_neg(64'((x < 0) ? -x : x));
         gain_lut[k] = (x >= 0) ? 32'((64'd1 << 48) / (64'd2147483648 + e))
                                : 32'((e << 17) / (64'd2147483648 + e));
      end

      // extremes, each command, repeated indices, gain at both ends of its span
      vectors.push_back(vec(tseu_pkg::CMD_WRITE, 0, 1023, 1023, 0, 32'h7FFF_FFFF, 'hFFFF, 1, 0));
      vectors.push_back(vec(tseu_pkg::CMD_WRITE, 0, 0, 0, 1, 32'h8000_0000, 0, 1, 0));
      vectors.push_back(vec(tseu_pkg::CMD_READ, 0, 1023, 0, 0, 0, 0, 1, 32'h7FFF_FFFF));
      vectors.push_back(vec(tseu_pkg::CMD_READ, 0, 0, 1023, 1, 32'hFFFF_FFFF, 0, 1,
                            32'h8000_0000));
      vectors.push_back(vec(tseu_pkg::CMD_WRITE, 1023, 0, 0, 0, 0, 0, 1, 0));
      vectors.push_back(vec(tseu_pkg::CMD_WRITE, 1023, 0, 0, 1, 0, 0, 1, 0));
      vectors.push_back(vec(tseu_pkg::CMD_WRITE, 5, 0, 0, 0, 32'h0001_0000, 0, 1, 0));
      vectors.push_back(vec(tseu_pkg::CMD_WRITE, 5, 0, 0, 1, 32'hFFFF_0000, 0, 1, 0));
      vectors.push_back(vec(tseu_pkg::CMD_WRITE, 1023, 0, 0, 15, 32'hFFFF_FFFF, 0, 1, 0));
      vectors.push_back(vec(tseu_pkg::CMD_READ, 1023, 0, 0, 15, 0, 0, 1, 32'hFFFF_FFFF));
      vectors.push_back(vec(tseu_pkg::CMD_NONE, 1023, 1023, 1023, 15, 32'hFFFF_FFFF, 'hFFFF,
                            1, 0));
      vectors.push_back(vec(tseu_pkg::CMD_TRAIN, 5, 1023, 5, 0, 0, 0, 0, 0));
      vectors.push_back(vec(tseu_pkg::CMD_TRAIN, 5, 5, 5, 0, 0, 'hFFFF, 0, 0));
      vectors.push_back(vec(tseu_pkg::CMD_TRAIN, 0, 1023, 5, 0, 0, 0, 0, 0));
      vectors.push_back(vec(tseu_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
      vectors.push_back(vec(tseu_pkg::CMD_TRAIN, 1023, 0, 5, 0, 0, 'hFFFF, 0, 0));
      vectors.push_back(vec(tseu_pkg::CMD_TRAIN, 0, 0, 5, 0, 0, 3, 0, 0));
      vectors.push_back(vec(tseu_pkg::CMD_READ, 1023, 0, 0, 1, 0, 0, 0, 0));
      vectors.push_back(vec(tseu_pkg::CMD_READ, 5, 0, 0, 0, 0, 0, 0, 0));

      settings = '{
         '{32'd2,  32'h0100_0000, 32'h0100_0000, 32'd0},
         '{32'd16, 32'hFFFF_FFFF, 32'd0,         32'd0},
         '{32'd1,  32'h0040_0000, 32'hFFFF_FFFF, 32'd0},
         '{32'd0,  32'h0100_0000, 32'h0100_0000, 32'd1},
         '{32'd31, 32'h0004_0000, 32'h00E6_6666, 32'd1},
         '{32'd16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1},
         '{32'd17, 32'h0010_0000, 32'h0100_0000, 32'd1},
         '{32'd8,  32'h0020_0000, 32'h0000_1000, 32'd0},
         '{32'd16, 32'd0,         32'h0080_0000, 32'd1},
         '{32'd4,  32'h0008_0000, 32'h0000_0100, 32'd0}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (vectors[i]) send_request(vectors[i].req, vectors[i].fixed, vectors[i].rsp);

      // load every dimension of the training pool
      foreach (pool[i])
         for (int d = 0; d < tseu_pkg::MAX_DIMS; d++) begin
            r = '{cmd: tseu_pkg::CMD_WRITE, point_a: 10'(pool[i]), point_b: 10'($urandom),
                  point_c: 10'($urandom), coord_index: 4'(d), coord_value: coord_rand(),
                  epoch: 16'($urandom)};
            send_request(r, 1'b0, '0);
         end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         // drop start so the last request is not taken again once idle
         @(negedge clock);
         start = 1'b0;
         wait_drained();
         repeat (4) @(posedge clock);
         write_csr(tseu_pkg::CSR_DIMS, settings[ph].dims);
         write_csr(tseu_pkg::CSR_STEP_INIT, settings[ph].eta0);
         write_csr(tseu_pkg::CSR_STEP_PARAM, settings[ph].param);
         write_csr(tseu_pkg::CSR_MODE, settings[ph].mode);
         no_idle = (ph == N_PHASES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ((ph == 1 && n == 40) || $urandom_range(0, 99) == 0) begin
               @(negedge clock);
               start = 1'b0;
               wait_drained();
            end
            send_request(random_request(), 1'b0, '0);
         end
      end

      @(negedge clock);
      start = 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tseu_pkg.sv
rtl/tseu_gain_rom.sv
rtl/tseu_divider.sv
rtl/triplet_embedding_sgd_update_unit.sv
dv/tb_triplet_embedding_sgd_update_unit.sv
